// ===== rtl/png_row_unfilter_unit_macros.svh =====
// assertion macros used by the checker file
`ifndef PNG_ROW_UNFILTER_UNIT_MACROS_SVH
`define PNG_ROW_UNFILTER_UNIT_MACROS_SVH

// same-cycle implication, sampled at the rising clock edge, off during reset
`define PRU_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("png row unfilter check failed");

// next-cycle implication
`define PRU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("png row unfilter check failed");

`endif

// ===== rtl/pru_pkg.sv =====
`timescale 1ns / 1ps

package pru_pkg;

  // filter type of a row; anything above paeth is kept as the bad code
  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4,
    FILT_BAD   = 3'd5
  } filt_e;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_ROW_BYTES = 1'b0,
    CFG_BPP       = 1'b1
  } cfg_idx_e;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned RowBytesW = 14;
  localparam int unsigned BppW      = 3;

  // neighbor bytes of the sample being reconstructed
  typedef struct packed {
    logic [ByteW-1:0] left;
    logic [ByteW-1:0] above;
    logic [ByteW-1:0] upleft;
  } nbr_t;

endpackage

// ===== rtl/png_row_unfilter_unit.sv =====
`timescale 1ns / 1ps

// channel   | dir | transfer carries
// ----------+-----+------------------------------------------------------------
// s_axis    | in  | tdata: stream byte (filter type or filtered sample),
//           |     | tuser: start of image
// m_axis    | out | tdata: reconstructed sample, tlast: last byte of scanline,
//           |     | tuser: bad filter type
// cfg       | in  | index 0 row_bytes, index 1 bytes_per_pixel
//
// one byte per cycle while the output does not stall: each transfer is
// reconstructed in the cycle it is taken and lands in the output register, so
// the line store reads the above byte early, at the next column's address.
// filter bytes give no output transfer; a sample byte gives one in the next cycle.
// s_axis_tready stays high while the output register is empty or being taken.
// rst_ni clears the control state; the line store is not cleared, the first
// row of an image reads its above bytes as zero.

module png_row_unfilter_unit #(
  parameter int unsigned MAX_ROW_BYTES = 8192,
  parameter int unsigned MAX_BPP       = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // [7:0] byte_value
  input  logic [0:0]                      s_axis_tuser,  // [0] start_image
  // output stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [7:0]                      m_axis_tdata,  // [7:0] pixel_byte
  output logic                            m_axis_tlast,
  output logic [0:0]                      m_axis_tuser,  // [0] bad_filter
  // configuration writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [0:0]                      cfg_index_i,
  input  logic [pru_pkg::RowBytesW-1:0]   cfg_data_i
);

  localparam int unsigned AW = $clog2(MAX_ROW_BYTES);
  localparam int unsigned LW = AW + 1;
  localparam int unsigned BW = (MAX_BPP > 1) ? $clog2(MAX_BPP) : 1;

  // configuration registers
  logic [pru_pkg::RowBytesW-1:0] row_bytes_q;
  logic [pru_pkg::BppW-1:0]      bpp_q;

  // row state
  logic [AW-1:0]          x_q, x_d;          // byte position in the row
  logic                   in_row_q, in_row_d; // low while a filter byte is due
  pru_pkg::filt_e         filt_q, filt_d;
  logic                   first_q, first_d;
  logic [7:0]             left_q [MAX_BPP];
  logic [7:0]             left_d [MAX_BPP];
  logic [7:0]             upl_q  [MAX_BPP];
  logic [7:0]             upl_d  [MAX_BPP];

  // output register
  logic                   out_valid_q, out_valid_d;
  logic [7:0]             out_byte_q;
  logic                   out_last_q;
  logic                   out_bad_q;

  logic                   accept;
  logic                   filt_byte;
  logic                   data_take;
  logic [LW-1:0]          len;
  logic [BW-1:0]          bsel;
  logic                   last;
  logic [7:0]             above_raw;
  pru_pkg::nbr_t          nbr;
  logic [7:0]             recon;
  logic                   bad;
  pru_pkg::filt_e         filt_new;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_bytes_q <= pru_pkg::RowBytesW'(1);
      bpp_q       <= pru_pkg::BppW'(1);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        pru_pkg::CFG_ROW_BYTES: row_bytes_q <= cfg_data_i;
        pru_pkg::CFG_BPP:       bpp_q       <= cfg_data_i[pru_pkg::BppW-1:0];
        default: ;
      endcase
    end
  end

  // effective row length, clamped to 1..MAX_ROW_BYTES
  always_comb begin
    if (row_bytes_q == '0) begin
      len = LW'(1);
    end else if (32'(row_bytes_q) > MAX_ROW_BYTES) begin
      len = LW'(MAX_ROW_BYTES);
    end else begin
      len = LW'(row_bytes_q);
    end
  end

  // tap of the left history, bytes per pixel clamped to 1..MAX_BPP
  always_comb begin
    if (bpp_q == '0) begin
      bsel = '0;
    end else if (32'(bpp_q) > MAX_BPP) begin
      bsel = BW'(MAX_BPP - 1);
    end else begin
      bsel = BW'(bpp_q - pru_pkg::BppW'(1));
    end
  end

  // handshake: the output register frees up in the same cycle it is taken
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  // start of image drops the row in progress and counts as a filter byte
  assign filt_byte     = s_axis_tuser[0] || !in_row_q;
  assign data_take     = accept && !filt_byte;

  assign last = ({1'b0, x_q} + LW'(1)) >= len;

  assign filt_new = (s_axis_tdata > 8'd4) ? pru_pkg::FILT_BAD
                                          : pru_pkg::filt_e'(s_axis_tdata[2:0]);

  // previous row is all zeros on the first row of an image
  assign nbr.left   = left_q[bsel];
  assign nbr.upleft = upl_q[bsel];
  assign nbr.above  = first_q ? 8'd0 : above_raw;

  pru_predict u_predict (
    .filt_i   (filt_q),
    .sample_i (s_axis_tdata),
    .nbr_i    (nbr),
    .recon_o  (recon),
    .bad_o    (bad)
  );

  // next row state
  always_comb begin
    x_d      = x_q;
    in_row_d = in_row_q;
    filt_d   = filt_q;
    first_d  = first_q;
    left_d   = left_q;
    upl_d    = upl_q;
    if (accept) begin
      if (filt_byte) begin
        filt_d   = filt_new;
        in_row_d = 1'b1;
        x_d      = '0;
        if (s_axis_tuser[0]) begin
          first_d = 1'b1;
        end
        for (int i = 0; i < MAX_BPP; i++) begin
          left_d[i] = '0;
          upl_d[i]  = '0;
        end
      end else begin
        left_d[0] = recon;
        upl_d[0]  = nbr.above;
        for (int i = 1; i < MAX_BPP; i++) begin
          left_d[i] = left_q[i-1];
          upl_d[i]  = upl_q[i-1];
        end
        if (last) begin
          in_row_d = 1'b0;
          first_d  = 1'b0;
          x_d      = '0;
        end else begin
          x_d = x_q + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q      <= '0;
      in_row_q <= 1'b0;
      filt_q   <= pru_pkg::FILT_NONE;
      first_q  <= 1'b1;
      for (int i = 0; i < MAX_BPP; i++) begin
        left_q[i] <= '0;
        upl_q[i]  <= '0;
      end
    end else begin
      x_q      <= x_d;
      in_row_q <= in_row_d;
      filt_q   <= filt_d;
      first_q  <= first_d;
      left_q   <= left_d;
      upl_q    <= upl_d;
    end
  end

  // line store: written at the current column, read at the next one so the
  // above byte is ready when that column's transfer comes in
  pru_ram #(
    .WIDTH (8),
    .DEPTH (MAX_ROW_BYTES)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (data_take),
    .waddr_i (x_q),
    .wdata_i (recon),
    .raddr_i (x_d),
    .rdata_o (above_raw)
  );

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (data_take) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (data_take) begin
      out_byte_q <= recon;
      out_last_q <= last;
      out_bad_q  <= bad;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_byte_q;
  assign m_axis_tlast    = out_last_q;
  assign m_axis_tuser[0] = out_bad_q;

endmodule

// ===== rtl/pru_ram.sv =====
`timescale 1ns / 1ps

module pru_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/pru_predict.sv =====
`timescale 1ns / 1ps

module pru_predict (
  input  pru_pkg::filt_e              filt_i,
  input  logic [pru_pkg::ByteW-1:0]   sample_i,
  input  pru_pkg::nbr_t               nbr_i,
  output logic [pru_pkg::ByteW-1:0]   recon_o,
  output logic                        bad_o
);

  logic [pru_pkg::ByteW:0]   avg_sum;
  logic signed [9:0]         pa, pb, pc;
  logic signed [9:0]         sa, sb, sc;
  logic [pru_pkg::ByteW-1:0] paeth_pred;

  assign sa = 10'(signed'({2'b00, nbr_i.left}));
  assign sb = 10'(signed'({2'b00, nbr_i.above}));
  assign sc = 10'(signed'({2'b00, nbr_i.upleft}));

  // distances of p = a + b - c to each neighbor
  always_comb begin
    pa = sb - sc;
    pb = sa - sc;
    pc = sa + sb - sc - sc;
    if (pa < 0) pa = -pa;
    if (pb < 0) pb = -pb;
    if (pc < 0) pc = -pc;
  end

  // ties go left, then above, then upper-left
  always_comb begin
    if (pa <= pb && pa <= pc) begin
      paeth_pred = nbr_i.left;
    end else if (pb <= pc) begin
      paeth_pred = nbr_i.above;
    end else begin
      paeth_pred = nbr_i.upleft;
    end
  end

  assign avg_sum = {1'b0, nbr_i.left} + {1'b0, nbr_i.above};

  always_comb begin
    bad_o = 1'b0;
    case (filt_i)
      pru_pkg::FILT_NONE:  recon_o = sample_i;
      pru_pkg::FILT_SUB:   recon_o = sample_i + nbr_i.left;
      pru_pkg::FILT_UP:    recon_o = sample_i + nbr_i.above;
      pru_pkg::FILT_AVG:   recon_o = sample_i + avg_sum[pru_pkg::ByteW:1];
      pru_pkg::FILT_PAETH: recon_o = sample_i + paeth_pred;
      default: begin
        recon_o = '0;
        bad_o   = 1'b1;
      end
    endcase
  end

endmodule

// ===== rtl/pru_checker.sv =====
`timescale 1ns / 1ps
`include "png_row_unfilter_unit_macros.svh"

module pru_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast,
  input logic [0:0] m_axis_tuser
);

  logic       m_stall;
  logic [9:0] m_beat;

  assign m_stall = m_axis_tvalid && !m_axis_tready;
  assign m_beat  = {m_axis_tuser, m_axis_tlast, m_axis_tdata};

  // a stalled output transfer holds
  `PRU_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_stall, m_axis_tvalid && $stable(m_beat))

  // a bad filter type always gives a zero sample
  `PRU_ASSERT_NOW(a_bad_zero, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == 8'd0)

  // input side never blocks while the output register is empty
  `PRU_ASSERT_NOW(a_ready_empty, clk_i, rst_ni, !m_axis_tvalid, s_axis_tready)

  // input side keeps flowing while the output is being taken
  `PRU_ASSERT_NOW(a_ready_flow, clk_i, rst_ni, m_axis_tvalid && m_axis_tready, s_axis_tready)

endmodule

bind png_row_unfilter_unit pru_checker u_pru_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);
